>>> rtl/bwco_pkg.sv
// Shared types, widths, register codes and the pointer bitmap for the
// blit-with-cursor-overlay block. No dependencies.
package bwco_pkg;

  // Field widths
  localparam int COORD_W    = 11;  // signed blit/view offsets
  localparam int PTR_POS_W  = 10;  // pointer column/row
  localparam int SIZE_W     = 11;  // source width/height
  localparam int CNT_W      = 10;  // raster counters
  localparam int COLOR_W    = 32;
  localparam int ADDR_W     = 19;
  localparam int POS_W      = 14;  // signed screen positions, room for compares up to 8191
  localparam int PTR_AXIS_W = 6;   // pointer window axis, up to 64
  localparam int PTR_IDX_W  = 2 * PTR_AXIS_W;

  // Default geometry
  localparam int DEFAULT_FB_WIDTH  = 640;
  localparam int DEFAULT_FB_HEIGHT = 480;
  localparam int DEFAULT_POINTER_W = 12;
  localparam int DEFAULT_POINTER_H = 18;

  // Stream port widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;

  // APB port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_BLIT_X      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BLIT_Y      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_X      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_Y      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_POINTER_COL = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_POINTER_ROW = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd7;

  // Register reset values
  localparam logic [PTR_POS_W-1:0] RST_POINTER_COL = 10'd320;
  localparam logic [PTR_POS_W-1:0] RST_POINTER_ROW = 10'd240;
  localparam logic [SIZE_W-1:0]    RST_SRC_SIZE    = 11'd1;
  localparam logic [SIZE_W-1:0]    MAX_SRC_SIZE    = 11'd1024;

  // Pointer bitmap: 12 x 18 pixels, flat index row * 12 + col.
  // Opaque pixels are either white or near-black outline.
  localparam int PTR_ROM_PIXELS = 216;
  localparam int PTR_ROM_IDX_W  = 8;

  localparam logic [COLOR_W-1:0] PTR_COLOR_WHITE = 32'h00FF_FFFF;
  localparam logic [COLOR_W-1:0] PTR_COLOR_EDGE  = 32'h0000_0001;

  // Rows listed bottom first; within a row column 11 is leftmost
  localparam logic [PTR_ROM_PIXELS-1:0] PTR_OPAQUE = {
    12'b000110000000, 12'b001111000000, 12'b001111000011, 12'b000111100111,
    12'b000111101111, 12'b000011111111, 12'b111111111111, 12'b111111111111,
    12'b011111111111, 12'b001111111111, 12'b000111111111, 12'b000011111111,
    12'b000001111111, 12'b000000111111, 12'b000000011111, 12'b000000001111,
    12'b000000000111, 12'b000000000011
  };

  localparam logic [PTR_ROM_PIXELS-1:0] PTR_WHITE = {
    12'b000000000000, 12'b000110000000, 12'b000110000000, 12'b000011000010,
    12'b000011000110, 12'b000001101110, 12'b000001111110, 12'b011111111110,
    12'b001111111110, 12'b000111111110, 12'b000011111110, 12'b000001111110,
    12'b000000111110, 12'b000000011110, 12'b000000001110, 12'b000000000110,
    12'b000000000010, 12'b000000000000
  };

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [COORD_W-1:0]   blit_x;
    logic [COORD_W-1:0]   blit_y;
    logic [COORD_W-1:0]   view_x;
    logic [COORD_W-1:0]   view_y;
    logic [PTR_POS_W-1:0] pointer_col;
    logic [PTR_POS_W-1:0] pointer_row;
    logic [SIZE_W-1:0]    src_width;
    logic [SIZE_W-1:0]    src_height;
  } cfg_t;

  // One source pixel with its raster position
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [CNT_W-1:0]   col;
    logic [CNT_W-1:0]   row;
    logic               last;
  } px_t;

  // Framebuffer write for one pixel
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               hit;
  } res_t;

endpackage

>>> rtl/bwco_cfg_regs.sv
// APB configuration register file for the blit-with-cursor-overlay block.
// Depends on bwco_pkg.
module bwco_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bwco_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bwco_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bwco_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output bwco_pkg::cfg_t                 cfg
);
  import bwco_pkg::*;

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blit_x      <= '0;
      cfg.blit_y      <= '0;
      cfg.view_x      <= '0;
      cfg.view_y      <= '0;
      cfg.pointer_col <= RST_POINTER_COL;
      cfg.pointer_row <= RST_POINTER_ROW;
      cfg.src_width   <= RST_SRC_SIZE;
      cfg.src_height  <= RST_SRC_SIZE;
    end else if (wr) begin
      case (idx)
        REG_BLIT_X:      cfg.blit_x      <= pwdata[COORD_W-1:0];
        REG_BLIT_Y:      cfg.blit_y      <= pwdata[COORD_W-1:0];
        REG_VIEW_X:      cfg.view_x      <= pwdata[COORD_W-1:0];
        REG_VIEW_Y:      cfg.view_y      <= pwdata[COORD_W-1:0];
        REG_POINTER_COL: cfg.pointer_col <= pwdata[PTR_POS_W-1:0];
        REG_POINTER_ROW: cfg.pointer_row <= pwdata[PTR_POS_W-1:0];
        REG_SRC_WIDTH:   cfg.src_width   <= pwdata[SIZE_W-1:0];
        REG_SRC_HEIGHT:  cfg.src_height  <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    case (idx)
      REG_BLIT_X:      prdata = CFG_DATA_W'(cfg.blit_x);
      REG_BLIT_Y:      prdata = CFG_DATA_W'(cfg.blit_y);
      REG_VIEW_X:      prdata = CFG_DATA_W'(cfg.view_x);
      REG_VIEW_Y:      prdata = CFG_DATA_W'(cfg.view_y);
      REG_POINTER_COL: prdata = CFG_DATA_W'(cfg.pointer_col);
      REG_POINTER_ROW: prdata = CFG_DATA_W'(cfg.pointer_row);
      REG_SRC_WIDTH:   prdata = CFG_DATA_W'(cfg.src_width);
      REG_SRC_HEIGHT:  prdata = CFG_DATA_W'(cfg.src_height);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> rtl/bwco_raster.sv
// Column/row counters that walk the source image in raster order.
// Depends on bwco_pkg.
module bwco_raster (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic [bwco_pkg::SIZE_W-1:0]  src_width,
  input  logic [bwco_pkg::SIZE_W-1:0]  src_height,
  output logic [bwco_pkg::CNT_W-1:0]   col,
  output logic [bwco_pkg::CNT_W-1:0]   row,
  output logic                         last
);
  import bwco_pkg::*;

  logic [CNT_W-1:0] w_m1;
  logic [CNT_W-1:0] h_m1;
  logic             col_end;
  logic             row_end;

  // Last position per axis; zero acts as one, above 1024 acts as 1024
  function automatic logic [CNT_W-1:0] size_m1(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] c;
    begin
      if (s == '0) c = RST_SRC_SIZE;
      else if (s > MAX_SRC_SIZE) c = MAX_SRC_SIZE;
      else c = s;
      size_m1 = CNT_W'(c - RST_SRC_SIZE);
    end
  endfunction

  assign w_m1    = size_m1(src_width);
  assign h_m1    = size_m1(src_height);
  assign col_end = col >= w_m1;
  assign row_end = row >= h_m1;
  assign last    = col_end && row_end;

  // Advance one pixel per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (adv) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_wrap_at_last: assert property (@(posedge clk) disable iff (rst)
    adv && last |=> col == '0 && row == '0)
    else $error("raster counters did not return to origin after last pixel");

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    adv && !col_end |=> col == $past(col) + 1'b1 && row == $past(row))
    else $error("column counter step wrong");

  a_reset_origin: assert property (@(posedge clk)
    rst |=> col == '0 && row == '0)
    else $error("raster counters not cleared by reset");
`endif

endmodule

>>> rtl/bwco_pixel.sv
// Per-pixel placement, clipping, address and pointer overlay logic.
// Purely combinational; depends on bwco_pkg.
module bwco_pixel #(
  parameter int FB_WIDTH  = bwco_pkg::DEFAULT_FB_WIDTH,
  parameter int FB_HEIGHT = bwco_pkg::DEFAULT_FB_HEIGHT,
  parameter int POINTER_W = bwco_pkg::DEFAULT_POINTER_W,
  parameter int POINTER_H = bwco_pkg::DEFAULT_POINTER_H
) (
  input  bwco_pkg::cfg_t cfg,
  input  bwco_pkg::px_t  px,
  output bwco_pkg::res_t res
);
  import bwco_pkg::*;

  localparam logic signed [POS_W-1:0] FB_W_S  = POS_W'(FB_WIDTH);
  localparam logic signed [POS_W-1:0] FB_H_S  = POS_W'(FB_HEIGHT);
  localparam logic signed [POS_W-1:0] PTR_W_S = POS_W'(POINTER_W);
  localparam logic signed [POS_W-1:0] PTR_H_S = POS_W'(POINTER_H);

  logic signed [POS_W-1:0] src_x, src_y;   // image position before view offset
  logic signed [POS_W-1:0] sx, sy;         // screen position
  logic signed [POS_W-1:0] cx, cy;         // position inside pointer window
  logic                    in_fb, in_win, rom_ok, opaque;
  logic [PTR_IDX_W-1:0]    ptr_idx;
  logic [PTR_ROM_IDX_W-1:0] rom_idx;
  logic [ADDR_W-1:0]       addr;

  always_comb begin
    src_x = POS_W'($signed(cfg.blit_x)) + $signed(POS_W'(px.col));
    src_y = POS_W'($signed(cfg.blit_y)) + $signed(POS_W'(px.row));
    sx    = src_x + POS_W'($signed(cfg.view_x));
    sy    = src_y + POS_W'($signed(cfg.view_y));
    // view offset cancels between pixel and pointer origin
    cx    = src_x - $signed(POS_W'(cfg.pointer_col));
    cy    = src_y - $signed(POS_W'(cfg.pointer_row));

    in_fb  = (sx >= 0) && (sy >= 0) && (sx < FB_W_S) && (sy < FB_H_S);
    in_win = (cx >= 0) && (cy >= 0) && (cx < PTR_W_S) && (cy < PTR_H_S);

    // Bitmap lookup; positions past the bitmap read as transparent
    ptr_idx = PTR_IDX_W'(cy[PTR_AXIS_W-1:0]) * PTR_IDX_W'(POINTER_W)
              + PTR_IDX_W'(cx[PTR_AXIS_W-1:0]);
    rom_idx = ptr_idx[PTR_ROM_IDX_W-1:0];
    rom_ok  = in_win && (ptr_idx < PTR_IDX_W'(PTR_ROM_PIXELS));
    opaque  = rom_ok && PTR_OPAQUE[rom_idx];

    addr = ADDR_W'(sy[POS_W-1:0]) * ADDR_W'(FB_WIDTH) + ADDR_W'(sx[POS_W-1:0]);

    res.we    = in_fb;
    res.hit   = in_fb && opaque;
    res.addr  = in_fb ? addr : '0;
    if (!in_fb) res.color = '0;
    else if (opaque) res.color = PTR_WHITE[rom_idx] ? PTR_COLOR_WHITE : PTR_COLOR_EDGE;
    else res.color = px.color;
  end

endmodule

>>> rtl/blit_with_cursor_overlay.sv
// Clipped blit with hardware pointer overlay. Source pixels arrive in raster
// order, one per transaction, and leave as framebuffer writes (address,
// colour, write enable, pointer hit, last). The block sustains one pixel per
// clock while the output is not stalled; an accepted pixel passes the input
// register, then the result register, and a stall can hold it in between.
// Placement, clipping, the address multiply and the pointer bitmap lookup
// sit between those two registers. The user must write registers over APB
// only while no pixel is in flight; the block itself does not enforce it.
// Depends on bwco_pkg, bwco_cfg_regs, bwco_raster and bwco_pixel.
module blit_with_cursor_overlay #(
  parameter int FB_WIDTH  = bwco_pkg::DEFAULT_FB_WIDTH,
  parameter int FB_HEIGHT = bwco_pkg::DEFAULT_FB_HEIGHT,
  parameter int POINTER_W = bwco_pkg::DEFAULT_POINTER_W,
  parameter int POINTER_H = bwco_pkg::DEFAULT_POINTER_H
) (
  input  logic                             clk,
  input  logic                             rst,
  // source pixels
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [bwco_pkg::IN_TDATA_W-1:0]  s_tdata,   // [31:0] pixel_color
  // framebuffer writes
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bwco_pkg::OUT_TDATA_W-1:0] m_tdata,   // [18:0] fb_address, [50:19] out_color
  output logic [bwco_pkg::OUT_TUSER_W-1:0] m_tuser,   // [0] write_enable, [1] pointer_hit
  output logic                             m_tlast,   // last_pixel
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bwco_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [bwco_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [bwco_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import bwco_pkg::*;

  cfg_t             cfg;
  logic             in_acc;
  logic             out_free;
  logic [CNT_W-1:0] col, row;
  logic             last;
  logic             s1_valid;
  px_t              s1;
  res_t             res;
  res_t             o_res;
  logic             o_last;

  bwco_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: result register frees when empty or taken
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || out_free;
  assign in_acc   = s_tvalid && s_tready;

  bwco_raster u_raster (
    .clk        (clk),
    .rst        (rst),
    .adv        (in_acc),
    .src_width  (cfg.src_width),
    .src_height (cfg.src_height),
    .col        (col),
    .row        (row),
    .last       (last)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1.color <= s_tdata[COLOR_W-1:0];
      s1.col   <= col;
      s1.row   <= row;
      s1.last  <= last;
    end
  end

  bwco_pixel #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT),
    .POINTER_W (POINTER_W),
    .POINTER_H (POINTER_H)
  ) u_pixel (
    .cfg (cfg),
    .px  (s1),
    .res (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      o_res  <= res;
      o_last <= s1.last;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - ADDR_W - COLOR_W){1'b0}}, o_res.color, o_res.addr};
  assign m_tuser = {o_res.hit, o_res.we};
  assign m_tlast = o_last;

`ifndef SYNTHESIS
  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
    else $error("clipped pixel carries address, colour or pointer hit");

  a_pending_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid)
    else $error("pixel in input register lost while output stalled");

  a_fill_output: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_free |=> m_tvalid)
    else $error("pixel moved from input register without a result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s1_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
